// ===== rtl/gcs_pkg.sv =====
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types, codes and tables for the GRU cell step block.
// ----------------------------------------------------------------------------
package gcs_pkg;

  localparam int HIDDEN_UNITS_DEF  = 10;
  localparam int FEATURE_COUNT_DEF = 5;
  localparam int FRACTION_BITS_DEF = 12;
  localparam int FEATURE_MAX       = 5;

  // request function codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_STEP  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // datapath pipeline operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP  = 4'd0;
  localparam op_t OP_BIAS = 4'd1;   // acc = bias, rec = 0
  localparam op_t OP_MACX = 4'd2;   // acc += w * x
  localparam op_t OP_MACH = 4'd3;   // acc += w * h
  localparam op_t OP_MACR = 4'd4;   // rec += w * h
  localparam op_t OP_ACTZ = 4'd5;   // z = sig(acc)
  localparam op_t OP_ACTR = 4'd6;   // r = sig(acc)
  localparam op_t OP_RECR = 4'd7;   // acc += rec * r
  localparam op_t OP_ACTC = 4'd8;   // cand = tanh(acc)
  localparam op_t OP_HN1  = 4'd9;   // t1 = (1 - z) * h_i
  localparam op_t OP_HN2  = 4'd10;  // hn_i = t1 + z * cand

  typedef struct packed {
    op_t  op;
    logic wr_en;
    logic clr_hidden;
    logic load_x;
    logic copy_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic int store_size(input int h, input int f);
    return 3 * h * f + 3 * h * h + 3 * h;
  endfunction

  // sig(k/2) in Q0.16, k = 0..16
  function automatic logic [16:0] sig_entry(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd32768;
      5'd1:    v = 17'd40793;
      5'd2:    v = 17'd47910;
      5'd3:    v = 17'd53580;
      5'd4:    v = 17'd57724;
      5'd5:    v = 17'd60564;
      5'd6:    v = 17'd62428;
      5'd7:    v = 17'd63615;
      5'd8:    v = 17'd64357;
      5'd9:    v = 17'd64816;
      5'd10:   v = 17'd65097;
      5'd11:   v = 17'd65269;
      5'd12:   v = 17'd65374;
      5'd13:   v = 17'd65437;
      5'd14:   v = 17'd65476;
      5'd15:   v = 17'd65500;
      default: v = 17'd65514;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/gcs_if.sv =====
// ----------------------------------------------------------------------------
// gcs_item_if / gcs_result_if
// Valid/ready channels carrying input requests and prediction results.
// ----------------------------------------------------------------------------
interface gcs_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [15:0] feature_0;
  logic signed [15:0] feature_1;
  logic signed [15:0] feature_2;
  logic signed [15:0] feature_3;
  logic signed [15:0] feature_4;
  logic [8:0]        weight_addr;
  logic signed [15:0] weight_value;

  modport source (output valid, func, feature_0, feature_1, feature_2, feature_3,
                  feature_4, weight_addr, weight_value, input ready);
  modport sink   (input valid, func, feature_0, feature_1, feature_2, feature_3,
                  feature_4, weight_addr, weight_value, output ready);
endinterface

interface gcs_result_if;
  logic              valid;
  logic              ready;
  logic signed [16:0] prediction;

  modport source (output valid, prediction, input ready);
  modport sink   (input valid, prediction, output ready);
endinterface

// ===== rtl/gcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcs_ctrl
// Sequencer walks units, gates, terms; one op per cycle bar gap/drain/copy/out.
// ----------------------------------------------------------------------------
module gcs_ctrl import gcs_pkg::*; #(
  parameter int HIDDEN_UNITS  = HIDDEN_UNITS_DEF,
  parameter int FEATURE_COUNT = FEATURE_COUNT_DEF,
  localparam int IW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1,
  localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1,
  localparam int AW = $clog2(store_size(HIDDEN_UNITS, FEATURE_COUNT))
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    in_func,
  output logic          in_ready,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] waddr,
  output logic [IW-1:0] hidx,
  output logic [FW-1:0] xidx,
  output logic [IW-1:0] unit
);

  localparam int H  = HIDDEN_UNITS;
  localparam int F  = FEATURE_COUNT;
  localparam int JW = (IW > FW) ? IW : FW;
  localparam int HF = H * F;
  localparam int HH = H * H;
  localparam int BASE_WZ = 0;
  localparam int BASE_WR = HF;
  localparam int BASE_WH = 2 * HF;
  localparam int BASE_UZ = 3 * HF;
  localparam int BASE_UR = 3 * HF + HH;
  localparam int BASE_UH = 3 * HF + 2 * HH;
  localparam int BASE_BZ = 3 * HF + 3 * HH;
  localparam int BASE_BR = BASE_BZ + H;
  localparam int BASE_BH = BASE_BZ + 2 * H;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BIAS  = 4'd1;
  localparam logic [3:0] S_MACX  = 4'd2;
  localparam logic [3:0] S_MACH  = 4'd3;
  localparam logic [3:0] S_ACT   = 4'd4;
  localparam logic [3:0] S_GAP   = 4'd5;
  localparam logic [3:0] S_RECR  = 4'd6;
  localparam logic [3:0] S_ACTC  = 4'd7;
  localparam logic [3:0] S_HN1   = 4'd8;
  localparam logic [3:0] S_HN2   = 4'd9;
  localparam logic [3:0] S_DRAIN = 4'd10;
  localparam logic [3:0] S_COPY  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]    state, state_next;
  logic [1:0]    g, g_next;
  logic [IW-1:0] i, i_next;
  logic [JW-1:0] j, j_next;
  logic [AW-1:0] wrow, wrow_next;
  logic [AW-1:0] urow, urow_next;
  logic [AW-1:0] bbase, wbase, ubase;
  logic          fire;

  assign in_ready = (state == S_IDLE);
  assign fire     = in_valid && in_ready;
  assign unit     = i;
  assign xidx     = j[FW-1:0];

  always_comb begin
    case (g)
      2'd0:    begin
        bbase = AW'(BASE_BZ); wbase = AW'(BASE_WZ); ubase = AW'(BASE_UZ);
      end
      2'd1:    begin
        bbase = AW'(BASE_BR); wbase = AW'(BASE_WR); ubase = AW'(BASE_UR);
      end
      default: begin
        bbase = AW'(BASE_BH); wbase = AW'(BASE_WH); ubase = AW'(BASE_UH);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    g_next     = g;
    i_next     = i;
    j_next     = j;
    wrow_next  = wrow;
    urow_next  = urow;
    cmd        = '0;
    cmd.op     = OP_NOP;
    waddr      = '0;
    hidx       = j[IW-1:0];
    case (state)
      S_IDLE: begin
        if (fire) begin
          case (in_func)
            FUNC_WRITE: cmd.wr_en = 1'b1;
            FUNC_STEP: begin
              cmd.load_x = 1'b1;
              g_next     = '0;
              i_next     = '0;
              j_next     = '0;
              wrow_next  = '0;
              urow_next  = '0;
              state_next = S_BIAS;
            end
            FUNC_CLEAR: cmd.clr_hidden = 1'b1;
            default: ;
          endcase
        end
      end
      S_BIAS: begin
        cmd.op     = OP_BIAS;
        waddr      = AW'(bbase + AW'(i));
        j_next     = '0;
        state_next = S_MACX;
      end
      S_MACX: begin
        cmd.op = OP_MACX;
        waddr  = AW'(wbase + wrow + AW'(j));
        if (j == JW'(F - 1)) begin
          j_next     = '0;
          state_next = S_MACH;
        end else begin
          j_next = JW'(j + 1'b1);
        end
      end
      S_MACH: begin
        cmd.op = (g == 2'd2) ? OP_MACR : OP_MACH;
        waddr  = AW'(ubase + urow + AW'(j));
        if (j == JW'(H - 1)) begin
          j_next     = '0;
          state_next = (g == 2'd2) ? S_GAP : S_ACT;
        end else begin
          j_next = JW'(j + 1'b1);
        end
      end
      S_ACT: begin
        cmd.op     = (g == 2'd0) ? OP_ACTZ : OP_ACTR;
        g_next     = 2'(g + 1'b1);
        state_next = S_BIAS;
      end
      S_GAP:  state_next = S_RECR;  // rec settles before it is read
      S_RECR: begin
        cmd.op     = OP_RECR;
        state_next = S_ACTC;
      end
      S_ACTC: begin
        cmd.op     = OP_ACTC;
        state_next = S_HN1;
      end
      S_HN1: begin
        cmd.op     = OP_HN1;
        hidx       = i;
        state_next = S_HN2;
      end
      S_HN2: begin
        cmd.op = OP_HN2;
        if (i == IW'(H - 1)) begin
          j_next     = '0;
          state_next = S_DRAIN;
        end else begin
          i_next     = IW'(i + 1'b1);
          g_next     = '0;
          wrow_next  = AW'(wrow + AW'(F));
          urow_next  = AW'(urow + AW'(H));
          state_next = S_BIAS;
        end
      end
      S_DRAIN: begin
        if (j == JW'(1)) begin
          j_next     = '0;
          state_next = S_COPY;
        end else begin
          j_next = JW'(j + 1'b1);
        end
      end
      S_COPY: begin
        cmd.copy_en = 1'b1;
        if (j == JW'(H - 1)) begin
          state_next = S_OUT;
        end else begin
          j_next = JW'(j + 1'b1);
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      g     <= '0;
      i     <= '0;
      j     <= '0;
      wrow  <= '0;
      urow  <= '0;
    end else begin
      state <= state_next;
      g     <= g_next;
      i     <= i_next;
      j     <= j_next;
      wrow  <= wrow_next;
      urow  <= urow_next;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded while output register busy");
  a_step_start: assert property (@(posedge clk) disable iff (rst)
    (fire && in_func == FUNC_STEP) |=> (state == S_BIAS && i == '0 && g == '0))
    else $error("step did not start at first unit");
  a_copy_after_drain: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_COPY) |-> $past(state) == S_DRAIN)
    else $error("copy started before pipeline drained");
  a_recr_gap: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_RECR) |-> $past(state) == S_GAP)
    else $error("rec*r issued without bubble");
`endif

endmodule

// ===== rtl/gcs_dp.sv =====
// ----------------------------------------------------------------------------
// gcs_dp
// Datapath: weight store, hidden state, shared MAC and activation unit.
// ----------------------------------------------------------------------------
module gcs_dp import gcs_pkg::*; #(
  parameter int HIDDEN_UNITS  = HIDDEN_UNITS_DEF,
  parameter int FEATURE_COUNT = FEATURE_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int IW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1,
  localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1,
  localparam int AW = $clog2(store_size(HIDDEN_UNITS, FEATURE_COUNT))
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [AW-1:0]      waddr,
  input  logic [IW-1:0]      hidx,
  input  logic [FW-1:0]      xidx,
  input  logic [IW-1:0]      unit,
  input  logic signed [15:0] features [FEATURE_MAX],
  input  logic [8:0]         weight_addr,
  input  logic signed [15:0] weight_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [16:0] prediction,
  output dp_stat_t           stat
);

  localparam int H  = HIDDEN_UNITS;
  localparam int F  = FEATURE_COUNT;
  localparam int FB = FRACTION_BITS;
  localparam int STORE = store_size(H, F);
  localparam int SW = 16 + IW + 1;
  localparam logic signed [32:0] MUL_HALF = 33'sd1 <<< (FB - 1);
  localparam logic signed [18:0] ACT_HALF = 19'sd1 <<< (15 - FB);
  localparam logic signed [15:0] ONE_Q    = 16'sd1 <<< FB;

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    if (v > 33'sd32767)       return 16'sh7fff;
    else if (v < -33'sd32768) return 16'sh8000;
    else                      return v[15:0];
  endfunction

  function automatic logic signed [15:0] qadd(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
    return sat16(33'(a) + 33'(b));
  endfunction

  // sigmoid in Q0.16: table lookup with linear interpolation, mirrored
  function automatic logic [16:0] sig_q16(input logic signed [16:0] x);
    logic [16:0]   ax;
    logic [16:0]   idx;
    logic [FB-2:0] frac;
    logic [16:0]   t0, t1, y;
    logic [30:0]   prod;
    ax   = x[16] ? 17'(-x) : 17'(x);
    idx  = ax >> (FB - 1);
    frac = ax[FB-2:0];
    t0   = sig_entry(idx[4:0]);
    t1   = sig_entry(5'(idx[4:0] + 1'b1));
    prod = 31'(t1 - t0) * 31'(frac);
    if (idx >= 17'd16) y = sig_entry(5'd16);
    else               y = 17'(t0 + 17'(prod >> (FB - 1)));
    return x[16] ? 17'(17'h10000 - y) : y;
  endfunction

  function automatic logic signed [15:0] act_q(input logic signed [16:0] x,
                                               input logic is_tanh);
    logic [16:0]        y;
    logic signed [18:0] t, v;
    y = sig_q16(x);
    t = is_tanh ? ($signed({1'b0, y, 1'b0}) - 19'sd65536) : $signed({2'b00, y});
    v = (t + ACT_HALF) >>> (16 - FB);
    return v[15:0];
  endfunction

  logic signed [15:0] wmem   [STORE];
  logic signed [15:0] hidden [H];
  logic signed [15:0] hn     [H];
  logic signed [15:0] x_r    [F];

  // pipeline registers
  op_t                op1, op2;
  logic signed [15:0] w1, w2, h1;
  logic [FW-1:0]      x1idx;
  logic [IW-1:0]      i1, i2;
  logic signed [31:0] prod2;
  logic signed [15:0] acc, rec, z, r, cand, t1;
  logic signed [SW-1:0] sum;

  logic signed [15:0] ma, mb, q;
  logic               wr_ok;

  assign wr_ok = cmd.wr_en && (32'(weight_addr) < STORE);

  always_ff @(posedge clk) begin
    if (wr_ok) wmem[AW'(weight_addr)] <= weight_value;
    w1 <= wmem[waddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      for (int k = 0; k < F; k++) x_r[k] <= features[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op1 <= OP_NOP;
      op2 <= OP_NOP;
    end else begin
      op1 <= cmd.op;
      op2 <= op1;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    ma = w1;
    mb = '0;
    case (op1)
      OP_MACX:          mb = x_r[x1idx];
      OP_MACH, OP_MACR: mb = h1;
      OP_RECR: begin ma = rec; mb = r; end
      OP_HN1:  begin ma = 16'(ONE_Q - z); mb = h1; end
      OP_HN2:  begin ma = z; mb = cand; end
      default: mb = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    h1    <= hidden[hidx];
    x1idx <= xidx;
    i1    <= unit;
    i2    <= i1;
    w2    <= w1;
    prod2 <= ma * mb;
  end

  assign q = sat16((33'(prod2) + MUL_HALF) >>> FB);

  always_ff @(posedge clk) begin
    case (op2)
      OP_BIAS: begin acc <= w2; rec <= '0; end
      OP_MACX, OP_MACH, OP_RECR: acc <= qadd(acc, q);
      OP_MACR: rec  <= qadd(rec, q);
      OP_ACTZ: z    <= act_q(17'(acc), 1'b0);
      OP_ACTR: r    <= act_q(17'(acc), 1'b0);
      OP_ACTC: cand <= act_q({acc, 1'b0}, 1'b1);
      OP_HN1:  t1   <= q;
      OP_HN2:  hn[i2] <= qadd(t1, q);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_hidden) begin
      for (int k = 0; k < H; k++) hidden[k] <= '0;
    end else if (cmd.copy_en) begin
      hidden[hidx] <= hn[hidx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x)       sum <= '0;
    else if (cmd.copy_en) sum <= SW'(sum + SW'(hn[hidx]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sum > SW'(65535))       prediction <= 17'sh0ffff;
      else if (sum < -SW'(65536)) prediction <= 17'sh10000;
      else                        prediction <= sum[16:0];
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/gru_cell_step.sv =====
// ----------------------------------------------------------------------------
// gru_cell_step
// GRU cell in signed fixed point: weight writes, recurrent steps, state clear.
// ----------------------------------------------------------------------------
// channel   dir  payload                                        notes
// items     in   func, feature_0..4, weight_addr, weight_value   one request each
// results   out  prediction                                     step requests only
//
// Write and clear requests complete on acceptance. A step runs the single
// shared multiplier through every weight term in turn before its result is
// valid; no new request is taken while a step is in progress.
// Reset clears the sequencer, the output valid and the hidden state; the
// weight store holds no reset value and must be written before use.
// A stalled result blocks only the final hand-off; the next request is
// taken as soon as the result is in the output register.
// ----------------------------------------------------------------------------
module gru_cell_step import gcs_pkg::*; #(
  parameter int HIDDEN_UNITS  = HIDDEN_UNITS_DEF,
  parameter int FEATURE_COUNT = FEATURE_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  gcs_item_if.sink     items,
  gcs_result_if.source results
);

  localparam int IW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int AW = $clog2(store_size(HIDDEN_UNITS, FEATURE_COUNT));

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [AW-1:0]      waddr;
  logic [IW-1:0]      hidx, unit;
  logic [FW-1:0]      xidx;
  logic               in_ready;
  logic signed [15:0] features [FEATURE_MAX];

  assign features[0] = items.feature_0;
  assign features[1] = items.feature_1;
  assign features[2] = items.feature_2;
  assign features[3] = items.feature_3;
  assign features[4] = items.feature_4;
  assign items.ready = in_ready;

  // sequencer: one op per cycle into the datapath, apart from the gap, drain, copy and output-wait states
  gcs_ctrl #(
    .HIDDEN_UNITS  (HIDDEN_UNITS),
    .FEATURE_COUNT (FEATURE_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_func  (items.func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .waddr    (waddr),
    .hidx     (hidx),
    .xidx     (xidx),
    .unit     (unit)
  );

  // weight store, hidden state, MAC, activations and result register
  gcs_dp #(
    .HIDDEN_UNITS  (HIDDEN_UNITS),
    .FEATURE_COUNT (FEATURE_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .waddr        (waddr),
    .hidx         (hidx),
    .xidx         (xidx),
    .unit         (unit),
    .features     (features),
    .weight_addr  (items.weight_addr),
    .weight_value (items.weight_value),
    .out_ready    (results.ready),
    .out_valid    (results.valid),
    .prediction   (results.prediction),
    .stat         (stat)
  );

endmodule
